// ===== hw/rtl/lnd_pkg.sv =====
`default_nettype none

package lnd_pkg;

  localparam int DATA_W          = 8;
  localparam int LEN_W           = 32;
  localparam int NIB_W           = 4;
  localparam int CNT_W           = 5;
  localparam int FLAG_CNT_W      = 4;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam logic [DATA_W-1:0]     START_POS = 8'hEF;
  localparam logic [CNT_W-1:0]      LEN_BIAS  = 5'd2;
  localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE_LEFT = 4'd7;

  // register index, decoded from paddr[2]
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_OFF,
    PH_LEN
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_COPY
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lnd_in_if.sv =====
`default_nettype none

interface lnd_in_if import lnd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] in_byte;
  logic              stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lnd_out_if.sv =====
`default_nettype none

interface lnd_out_if import lnd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              run_end;
  logic              stream_done;

  modport source (output valid, output out_byte, output run_end, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input stream_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzss_nibble_length_decompressor.sv =====
// A literal shows on the output in the cycle after its beat is taken; a back
// reference passes ST_PRIME, ST_COPY and the output register before its first byte.
// Throughput: flag, literal and offset beats are taken one per cycle unless the
// output stalls; a reference of n bytes (n = 2..17) holds the input while copied,
// one byte per cycle through the single window read port, plus output stalls.
// Reset and stream_start clear the window valid bits at once; no clearing pass.
`default_nettype none

module lzss_nibble_length_decompressor import lnd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  lnd_in_if.sink                  cstream,
  lnd_out_if.source               dstream
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  // configuration
  logic [LEN_W-1:0] output_length;

  // parser and engine state
  state_t                state, state_next;
  phase_t                phase, phase_next;
  logic [DATA_W-1:0]     flag_bits, flag_bits_next;
  logic [FLAG_CNT_W-1:0] flags_left, flags_left_next;
  logic [DATA_W-1:0]     length_byte, length_byte_next;
  logic                  high_nib, high_nib_next;
  logic [LEN_W-1:0]      bytes_produced, bytes_produced_next;
  logic [AW-1:0]         wpos, wpos_next;
  logic [AW-1:0]         src, src_next;
  logic [CNT_W-1:0]      count, count_next;

  // window memory
  logic [DATA_W-1:0]       mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] valid;
  logic [DATA_W-1:0]       mem_q, fwd_data, rd_data;
  logic                    vld_q, fwd;
  logic [AW-1:0]           rd_addr;
  logic                    we, vclr;
  logic [AW-1:0]           wa;
  logic [DATA_W-1:0]       wd;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_byte;
  logic              out_run_end, out_done;

  // combinational helpers
  logic              can_emit, accept, ss, active, emit, last, hit;
  logic [LEN_W-1:0]  prod_base;
  logic [AW-1:0]     wpos_base;
  phase_t            eff_phase, ni_phase;
  logic [DATA_W-1:0] eff_flags, ni_flags, eff_len, b;
  logic [FLAG_CNT_W-1:0] eff_left, ni_left;
  logic              eff_hn;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ? output_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_LENGTH) begin
      output_length <= pwdata;
    end
  end

  // ---------------- control ----------------
  assign can_emit      = !out_valid || dstream.ready;
  assign cstream.ready = (state == ST_IDLE) && can_emit;
  assign accept        = cstream.valid && cstream.ready;
  assign ss            = cstream.stream_start;
  assign b             = cstream.in_byte;

  // state as seen by this beat once a stream start has cleared it
  assign eff_phase = ss ? PH_FLAG : phase;
  assign eff_flags = ss ? '0 : flag_bits;
  assign eff_left  = ss ? '0 : flags_left;
  assign eff_len   = ss ? '0 : length_byte;
  assign eff_hn    = ss ? 1'b0 : high_nib;
  assign prod_base = (accept && ss) ? '0 : bytes_produced;
  assign wpos_base = (accept && ss) ? START_POS[AW-1:0] : wpos;
  assign active    = prod_base != output_length;
  assign hit       = (prod_base + 32'd1) == output_length;

  // pick the next flag, or wait for a flag byte
  assign ni_phase = (eff_left == '0) ? PH_FLAG : (eff_flags[7] ? PH_LIT : PH_OFF);
  assign ni_flags = (eff_left == '0) ? eff_flags : {eff_flags[DATA_W-2:0], 1'b0};
  assign ni_left  = (eff_left == '0) ? eff_left : eff_left - 1'b1;

  always_comb begin
    state_next          = state;
    phase_next          = phase;
    flag_bits_next      = flag_bits;
    flags_left_next     = flags_left;
    length_byte_next    = length_byte;
    high_nib_next       = high_nib;
    src_next            = src;
    count_next          = count;
    vclr                = 1'b0;
    emit                = 1'b0;
    last                = 1'b0;
    wd                  = b;
    rd_addr             = src;

    case (state)
      ST_IDLE: begin
        if (accept && ss) begin
          vclr             = 1'b1;
          phase_next       = PH_FLAG;
          flag_bits_next   = '0;
          flags_left_next  = '0;
          length_byte_next = '0;
          high_nib_next    = 1'b0;
        end
        if (accept && active) begin
          case (eff_phase)
            PH_FLAG: begin
              flag_bits_next  = {b[DATA_W-2:0], 1'b0};
              flags_left_next = FLAGS_PER_BYTE_LEFT;
              phase_next      = b[7] ? PH_LIT : PH_OFF;
            end
            PH_LIT: begin
              emit            = 1'b1;
              last            = 1'b1;
              wd              = b;
              phase_next      = ni_phase;
              flag_bits_next  = ni_flags;
              flags_left_next = ni_left;
            end
            PH_OFF: begin
              src_next = AW'(b);
              if (eff_hn) begin
                high_nib_next   = 1'b0;
                count_next      = {1'b0, eff_len[DATA_W-1:NIB_W]} + LEN_BIAS;
                state_next      = ST_PRIME;
                phase_next      = ni_phase;
                flag_bits_next  = ni_flags;
                flags_left_next = ni_left;
              end else begin
                phase_next = PH_LEN;
              end
            end
            default: begin
              length_byte_next = b;
              high_nib_next    = 1'b1;
              count_next       = {1'b0, b[NIB_W-1:0]} + LEN_BIAS;
              state_next       = ST_PRIME;
              phase_next       = ni_phase;
              flag_bits_next   = ni_flags;
              flags_left_next  = ni_left;
            end
          endcase
        end
      end
      ST_PRIME: begin
        state_next = ST_COPY;
      end
      ST_COPY: begin
        if (can_emit) begin
          emit       = 1'b1;
          wd         = rd_data;
          last       = (count == 5'd1) || hit;
          src_next   = src + 1'b1;
          rd_addr    = src + 1'b1;
          count_next = count - 1'b1;
          if (last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign we                  = emit;
  assign wa                  = wpos_base;
  assign wpos_next           = emit ? wpos_base + 1'b1 : wpos_base;
  assign bytes_produced_next = emit ? prod_base + 32'd1 : prod_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_FLAG;
      flag_bits      <= '0;
      flags_left     <= '0;
      length_byte    <= '0;
      high_nib       <= 1'b0;
      bytes_produced <= '0;
      wpos           <= START_POS[AW-1:0];
      src            <= '0;
      count          <= '0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      flag_bits      <= flag_bits_next;
      flags_left     <= flags_left_next;
      length_byte    <= length_byte_next;
      high_nib       <= high_nib_next;
      bytes_produced <= bytes_produced_next;
      wpos           <= wpos_next;
      src            <= src_next;
      count          <= count_next;
    end
  end

  // ---------------- window memory ----------------
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[rd_addr];
  end

  // forward a write that hits the address being read in the same cycle
  always_ff @(posedge clk) begin
    fwd      <= we && (wa == rd_addr);
    fwd_data <= wd;
    vld_q    <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || vclr) begin
      valid <= '0;
    end
    if (!rst && we) begin
      valid[wa] <= 1'b1;
    end
  end

  // never-written entries read as zero
  assign rd_data = fwd ? fwd_data : (vld_q ? mem_q : '0);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dstream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= wd;
      out_run_end <= last;
      out_done    <= hit;
    end
  end

  assign dstream.valid       = out_valid;
  assign dstream.out_byte    = out_byte;
  assign dstream.run_end     = out_run_end;
  assign dstream.stream_done = out_done;

  // ---------------- assertions ----------------
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_run_end)
    else $error("stream_done without run_end");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY || state == ST_PRIME) |-> count != '0)
    else $error("copy engine running with zero count");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    emit && hit |=> bytes_produced == output_length)
    else $error("produced count off at stream end");

  a_fwd_copy: assert property (@(posedge clk) disable iff (rst)
    fwd |-> state == ST_COPY || state == ST_IDLE)
    else $error("forward outside copy");

endmodule

`default_nettype wire
